// ----- src/pbb_pkg.sv -----
// ----------------------------------------------------------------------------
// pbb_pkg
// Types, constants and register codes shared by the palette bitmap blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pbb_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int MAX_STRETCH_DEF   = 8;
  localparam int COORD_BITS_DEF    = 12;
  localparam int IN_QUEUE_DEPTH    = 4;
  localparam int OUT_QUEUE_DEPTH   = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [1:0] {
    BPP_1  = 2'd0,
    BPP_4  = 2'd1,
    BPP_8  = 2'd2,
    BPP_16 = 2'd3
  } bpp_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP_MODE       = 3'd0,
    REG_STRETCH_FACTOR = 3'd1,
    REG_IMAGE_WIDTH    = 3'd2,
    REG_IMAGE_HEIGHT   = 3'd3,
    REG_ORIGIN_X       = 3'd4,
    REG_ORIGIN_Y       = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    REQ_PALETTE = 1'b0,
    REQ_DATA    = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SETUP,
    BS_GEN
  } back_state_e;

  localparam bpp_e        BPP_MODE_RST = BPP_8;
  localparam logic [3:0]  STRETCH_RST  = 4'd1;
  localparam logic [9:0]  WIDTH_RST    = 10'd320;
  localparam logic [9:0]  HEIGHT_RST   = 10'd240;
  localparam logic [11:0] ORIGIN_RST   = 12'd0;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  palette_index;
    logic [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] pixel_color;
    logic        last_of_run;
    logic        image_done;
  } out_item_t;

  typedef struct packed {
    bpp_e        bpp_mode;
    logic [3:0]  stretch_factor;
    logic [9:0]  image_width;
    logic [9:0]  image_height;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic        is_pal;
    logic        pal_ok;
    logic [7:0]  index;
    logic [15:0] word;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/pbb_fifo.sv -----
// ----------------------------------------------------------------------------
// pbb_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module pbb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           rdata_o,
  output logic                            empty_o,
  output logic                            full_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/pbb_front.sv -----
// ----------------------------------------------------------------------------
// pbb_front
// Input side: takes words and classifies them into palette writes and
// image data commands for the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pbb_front #(
  parameter int PALETTE_DEPTH = pbb_pkg::PALETTE_DEPTH_DEF
) (
  input  wire pbb_pkg::in_item_t in_item_i,
  input  wire logic              push_i,
  input  wire logic              q_full_i,
  output logic                   full_o,
  output logic                   q_push_o,
  output pbb_pkg::cmd_t          cmd_o
);

  import pbb_pkg::*;

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.is_pal = (req_e'(in_item_i.req_type) == REQ_PALETTE);
    cmd_o.pal_ok = ({1'b0, in_item_i.palette_index} < 9'(PALETTE_DEPTH));
    cmd_o.index  = in_item_i.palette_index;
    cmd_o.word   = in_item_i.data_word;
  end

endmodule

`default_nettype wire

// ----- src/pbb_back.sv -----
// ----------------------------------------------------------------------------
// pbb_back
// Execution side: palette store, pixel expansion, stretch and coordinates.
// One pixel issued per cycle while the result queue has room, palette read
// registered, then into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pbb_back #(
  parameter int PALETTE_DEPTH = pbb_pkg::PALETTE_DEPTH_DEF,
  parameter int MAX_STRETCH   = pbb_pkg::MAX_STRETCH_DEF,
  parameter int COORD_BITS    = pbb_pkg::COORD_BITS_DEF,
  parameter int ODEPTH        = pbb_pkg::OUT_QUEUE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pbb_pkg::cfg_t               cfg_i,
  input  wire pbb_pkg::cmd_t               cmd_i,
  input  wire logic                        q_empty_i,
  output logic                             q_pop_o,
  input  wire logic [$clog2(ODEPTH+1)-1:0] ocnt_i,
  output logic                             o_push_o,
  output pbb_pkg::out_item_t               o_item_o
);

  import pbb_pkg::*;

  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CB  = COORD_BITS;
  localparam int OCW = $clog2(ODEPTH + 1);

  logic [15:0] pal_mem [PALETTE_DEPTH];
  logic [15:0] pal_rdata_q;

  back_state_e state_q, state_d;
  logic [15:0] word_q, word_d;
  logic [3:0]  st_q, st_d;
  logic [2:0]  p_q, p_d;
  logic [3:0]  k_q, k_d;
  logic [9:0]  col_q, col_d;
  logic [13:0] row_q, row_d;
  logic [13:0] total_q, total_d;
  logic [CB-1:0] x_q, x_d, y_q, y_d;

  logic        s2_valid_q;
  logic [11:0] s2_x_q, s2_y_q;
  logic        s2_last_q, s2_done_q, s2_direct_q, s2_zero_q;
  logic [15:0] s2_color_q;

  logic [3:0]  st_eff;
  logic [9:0]  w_eff, h_eff;
  logic [13:0] total_c, row_eff, prod_cs;
  logic [16:0] xsum, ysum;
  logic [10:0] col_nx;
  logic [14:0] row_nx;
  logic [2:0]  npix_m1;
  logic [7:0]  idx8;
  logic        can_issue, issue, last_copy, row_end, last_pix, wrap;
  logic        pix_last, pix_done, pix_direct, pix_zero;
  logic        wr_en;
  logic [15:0] x_ext, y_ext;

  always_comb begin
    if (cfg_i.stretch_factor == 4'd0) begin
      st_eff = 4'd1;
    end else if (cfg_i.stretch_factor > 4'(MAX_STRETCH)) begin
      st_eff = 4'(MAX_STRETCH);
    end else begin
      st_eff = cfg_i.stretch_factor;
    end
    w_eff   = (cfg_i.image_width == '0) ? 10'd1 : cfg_i.image_width;
    h_eff   = (cfg_i.image_height == '0) ? 10'd1 : cfg_i.image_height;
    total_c = 14'({4'b0, h_eff} * {10'b0, st_eff});
    row_eff = (row_q >= total_c) ? '0 : row_q;
    prod_cs = 14'({4'b0, col_q} * {10'b0, st_eff});
    xsum    = {5'b0, cfg_i.origin_x} + {3'b0, prod_cs};
    ysum    = {5'b0, cfg_i.origin_y} + {3'b0, row_eff};
    unique case (cfg_i.bpp_mode)
      BPP_1:   npix_m1 = 3'd7;
      BPP_4:   npix_m1 = 3'd1;
      default: npix_m1 = 3'd0;
    endcase
    unique case (cfg_i.bpp_mode)
      BPP_1:   idx8 = {7'b0, word_q[p_q]};
      BPP_4:   idx8 = {4'b0, word_q[{p_q[0], 2'b00} +: 4]};
      default: idx8 = word_q[7:0];
    endcase
  end

  assign can_issue  = ({1'b0, ocnt_i} + {{OCW{1'b0}}, s2_valid_q}) < (OCW + 1)'(ODEPTH);
  assign issue      = (state_q == BS_GEN) && can_issue;
  assign last_copy  = ((k_q + 4'd1) == st_q);
  assign col_nx     = {1'b0, col_q} + 11'd1;
  assign row_end    = (col_nx >= {1'b0, w_eff});
  assign last_pix   = (p_q == npix_m1) || row_end;
  assign row_nx     = {1'b0, row_q} + 15'd1;
  assign wrap       = (row_nx >= {1'b0, total_q});
  assign pix_last   = last_copy && last_pix;
  assign pix_done   = pix_last && row_end && wrap;
  assign pix_direct = (cfg_i.bpp_mode == BPP_16);
  assign pix_zero   = ({1'b0, idx8} >= 9'(PALETTE_DEPTH));
  assign x_ext      = 16'(x_q);
  assign y_ext      = 16'(y_q);

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    st_d    = st_q;
    p_d     = p_q;
    k_d     = k_q;
    col_d   = col_q;
    row_d   = row_q;
    total_d = total_q;
    x_d     = x_q;
    y_d     = y_q;
    q_pop_o = 1'b0;
    wr_en   = 1'b0;
    unique case (state_q)
      BS_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (cmd_i.is_pal) begin
            wr_en = cmd_i.pal_ok;
          end else begin
            word_d  = cmd_i.word;
            state_d = BS_SETUP;
          end
        end
      end
      BS_SETUP: begin
        if (col_q >= w_eff) begin
          // column already past the edge: close the row, no pixels
          col_d   = '0;
          row_d   = ({1'b0, row_eff} + 15'd1 >= {1'b0, total_c}) ? '0 : row_eff + 14'd1;
          state_d = BS_IDLE;
        end else begin
          row_d   = row_eff;
          total_d = total_c;
          st_d    = st_eff;
          x_d     = xsum[CB-1:0];
          y_d     = ysum[CB-1:0];
          p_d     = '0;
          k_d     = '0;
          state_d = BS_GEN;
        end
      end
      BS_GEN: begin
        if (issue) begin
          x_d = x_q + 1'b1;
          if (last_copy) begin
            k_d = '0;
            p_d = p_q + 3'd1;
            col_d = row_end ? '0 : col_nx[9:0];
            if (row_end) begin
              row_d = wrap ? '0 : row_nx[13:0];
            end
            if (last_pix) begin
              state_d = BS_IDLE;
            end
          end else begin
            k_d = k_q + 4'd1;
          end
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BS_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s2_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    st_q    <= st_d;
    p_q     <= p_d;
    k_q     <= k_d;
    total_q <= total_d;
    x_q     <= x_d;
    y_q     <= y_d;
    if (issue) begin
      s2_x_q      <= x_ext[11:0];
      s2_y_q      <= y_ext[11:0];
      s2_last_q   <= pix_last;
      s2_done_q   <= pix_done;
      s2_direct_q <= pix_direct;
      s2_zero_q   <= pix_zero;
      s2_color_q  <= word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pal_mem[cmd_i.index[PAW-1:0]] <= cmd_i.word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pal_rdata_q <= pal_mem[idx8[PAW-1:0]];
    end
  end

  always_comb begin
    o_push_o             = s2_valid_q;
    o_item_o.pixel_x     = s2_x_q;
    o_item_o.pixel_y     = s2_y_q;
    o_item_o.last_of_run = s2_last_q;
    o_item_o.image_done  = s2_done_q;
    if (s2_direct_q) begin
      o_item_o.pixel_color = s2_color_q;
    end else if (s2_zero_q) begin
      o_item_o.pixel_color = '0;
    end else begin
      o_item_o.pixel_color = pal_rdata_q;
    end
  end

endmodule

`default_nettype wire

// ----- src/palette_bitmap_blitter_top.sv -----
// ----------------------------------------------------------------------------
// palette_bitmap_blitter_top
// Indexed-color bitmap blitter with integer stretch: palette writes and
// packed image words in, stretched pixels with screen coordinates out.
//
//   channel   direction  handshake          payload
//   input     in         push_i / full_o    in_item_i  (in_item_t)
//   result    out        pop_i / empty_o    out_item_o (out_item_t)
//   config    in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// A palette write is done in the dequeue step of the execution side; an image
// word takes a dequeue step, a setup step and the issue steps for its stretched
// pixels. The execution side issues one pixel per cycle while the result queue
// has room; the palette read adds one stage before the result queue. A full
// result queue stalls issue only; the command queue keeps accepting until it
// fills. Reset clears control, counters and config; the palette needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_bitmap_blitter_top #(
  parameter int PALETTE_DEPTH = pbb_pkg::PALETTE_DEPTH_DEF,
  parameter int MAX_STRETCH   = pbb_pkg::MAX_STRETCH_DEF,
  parameter int COORD_BITS    = pbb_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  wire pbb_pkg::in_item_t               in_item_i,
  output logic                                 full_o,
  input  wire logic                            pop_i,
  output logic                                 empty_o,
  output pbb_pkg::out_item_t                   out_item_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pbb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pbb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  import pbb_pkg::*;

  localparam int CW = $bits(cmd_t);
  localparam int OW = $bits(out_item_t);

  cfg_t      cfg_q;
  cmd_t      cmd_in, cmd_out;
  logic      q_push, q_pop, q_full, q_empty;
  logic [$clog2(IN_QUEUE_DEPTH+1)-1:0]  q_cnt;
  logic [$clog2(OUT_QUEUE_DEPTH+1)-1:0] o_cnt;
  logic [CW-1:0] q_rdata;
  logic [OW-1:0] o_rdata;
  logic      o_push, o_full;
  out_item_t o_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp_mode       <= BPP_MODE_RST;
      cfg_q.stretch_factor <= STRETCH_RST;
      cfg_q.image_width    <= WIDTH_RST;
      cfg_q.image_height   <= HEIGHT_RST;
      cfg_q.origin_x       <= ORIGIN_RST;
      cfg_q.origin_y       <= ORIGIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BPP_MODE:       cfg_q.bpp_mode       <= bpp_e'(cfg_wdata_i[1:0]);
        REG_STRETCH_FACTOR: cfg_q.stretch_factor <= cfg_wdata_i[3:0];
        REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_wdata_i[9:0];
        REG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_wdata_i[9:0];
        REG_ORIGIN_X:       cfg_q.origin_x       <= cfg_wdata_i;
        REG_ORIGIN_Y:       cfg_q.origin_y       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pbb_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .in_item_i(in_item_i),
    .push_i   (push_i),
    .q_full_i (q_full),
    .full_o   (full_o),
    .q_push_o (q_push),
    .cmd_o    (cmd_in)
  );

  pbb_fifo #(
    .WIDTH(CW),
    .DEPTH(IN_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(cmd_in),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty),
    .full_o (q_full),
    .count_o(q_cnt)
  );

  assign cmd_out = cmd_t'(q_rdata);

  pbb_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .MAX_STRETCH  (MAX_STRETCH),
    .COORD_BITS   (COORD_BITS),
    .ODEPTH       (OUT_QUEUE_DEPTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd_out),
    .q_empty_i(q_empty || (q_cnt == '0)),
    .q_pop_o  (q_pop),
    .ocnt_i   (o_cnt),
    .o_push_o (o_push),
    .o_item_o (o_item)
  );

  pbb_fifo #(
    .WIDTH(OW),
    .DEPTH(OUT_QUEUE_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (o_push),
    .wdata_i(o_item),
    .pop_i  (pop_i),
    .rdata_o(o_rdata),
    .empty_o(empty_o),
    .full_o (o_full),
    .count_o(o_cnt)
  );

  assign out_item_o = out_item_t'(o_rdata);

  // result queue never overflows: issue is credited against its count
  logic unused_full;
  assign unused_full = o_full;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for palette_bitmap_blitter_top. Palette writes and image
// words go in through the push/full side; every pixel popped from the result
// side is compared field by field against a local model of the blitter that
// tracks the palette, the current column and the stretched output row. Runs a
// short directed set (all pixel formats, stretch and size extremes, coordinate
// wrap, registers changed mid-image), a long output stall, then randomized
// image phases with random gaps on both sides.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pbb_pkg::*;

  localparam int TARGET_ITEMS = 410;
  localparam int DRAIN_CYCLES = 64;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_RUN      = 64;
  localparam int IN_W         = $bits(in_item_t);

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  push_i      = 1'b0;
  in_item_t              in_item_i   = '0;
  logic                  full_o;
  logic                  pop_i       = 1'b0;
  logic                  empty_o;
  out_item_t             out_item_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  palette_bitmap_blitter_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_item_i  (in_item_i),
    .full_o     (full_o),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // blitter model state
  logic [15:0] pal_mem   [PALETTE_DEPTH_DEF];
  bit          pal_valid [PALETTE_DEPTH_DEF];
  int          src_col = 0;
  int          out_row = 0;
  bpp_e        cur_bpp      = BPP_MODE_RST;
  logic [3:0]  cur_stretch  = STRETCH_RST;
  logic [9:0]  cur_width    = WIDTH_RST;
  logic [9:0]  cur_height   = HEIGHT_RST;
  logic [11:0] cur_origin_x = ORIGIN_RST;
  logic [11:0] cur_origin_y = ORIGIN_RST;

  out_item_t pending_pixels [$];

  int items_sent     = 0;
  int pixels_checked = 0;
  int images_seen    = 0;
  int mismatches     = 0;
  int cfg_writes     = 0;
  int tx_gap_pct     = 0;
  int rx_stall_pct   = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int stall_left     = 0;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic int eff_stretch();
    if (cur_stretch == 0) return 1;
    if (cur_stretch > MAX_STRETCH_DEF) return MAX_STRETCH_DEF;
    return int'(cur_stretch);
  endfunction

  function automatic int eff_width();
    return (cur_width == 0) ? 1 : int'(cur_width);
  endfunction

  function automatic int eff_height();
    return (cur_height == 0) ? 1 : int'(cur_height);
  endfunction

  function automatic int pix_per_word();
    case (cur_bpp)
      BPP_1: return 8;
      BPP_4: return 2;
      default: return 1;
    endcase
  endfunction

  // expand one accepted word into the pixels it should produce
  task automatic expand_word(input in_item_t it);
    out_item_t   run_px [MAX_RUN];
    out_item_t   px;
    int          st;
    int          w;
    int          total;
    int          npix;
    int          cnt;
    logic [15:0] color;
    logic [11:0] row_y;
    if (it.req_type == REQ_PALETTE) begin
      pal_mem[it.palette_index]   = it.data_word;
      pal_valid[it.palette_index] = 1'b1;
    end else begin
      st    = eff_stretch();
      w     = eff_width();
      total = eff_height() * st;
      npix  = pix_per_word();
      cnt   = 0;
      if (out_row >= total) out_row = 0;
      row_y = 12'(int'(cur_origin_y) + out_row);
      for (int p = 0; p < npix && src_col < w; p++) begin
        case (cur_bpp)
          BPP_1: color = pal_mem[{7'd0, it.data_word[p]}];
          BPP_4: color = pal_mem[{4'd0, it.data_word[4*p +: 4]}];
          BPP_8: color = pal_mem[it.data_word[7:0]];
          default: color = it.data_word;
        endcase
        for (int k = 0; k < st; k++) begin
          px.pixel_x     = 12'(int'(cur_origin_x) + src_col * st + k);
          px.pixel_y     = row_y;
          px.pixel_color = color;
          px.last_of_run = 1'b0;
          px.image_done  = 1'b0;
          run_px[cnt]    = px;
          cnt++;
        end
        src_col++;
      end
      if (src_col >= w) begin
        src_col = 0;
        out_row++;
        if (out_row >= total) begin
          out_row = 0;
          if (cnt > 0) run_px[cnt-1].image_done = 1'b1;
        end
      end
      if (cnt > 0) run_px[cnt-1].last_of_run = 1'b1;
      for (int i = 0; i < cnt; i++) pending_pixels.push_back(run_px[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    mismatches++;
    $display("MISMATCH %s: expected %0h, got %0h (t=%0t)", what, want_v, got_v, $realtime);
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("pixel with nothing pending (x,y)", 32'd0,
                      32'({got.pixel_x, got.pixel_y}));
    end else begin
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (want.image_done) images_seen++;
      if (got.pixel_x !== want.pixel_x)
        report_mismatch("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        report_mismatch("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
      if (got.pixel_color !== want.pixel_color)
        report_mismatch("pixel_color", 32'(want.pixel_color), 32'(got.pixel_color));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      if (got.image_done !== want.image_done)
        report_mismatch("image_done", 32'(want.image_done), 32'(got.image_done));
    end
  endtask

  // result side: pop with random stalls and an optional long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) check_pixel(out_item_o);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop_i <= 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = pick_gap() - 1;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((push_i && !full_o) || (pop_i && !empty_o)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: %0d cycles with no word moving", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(input in_item_t it);
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      push_i    <= 1'b0;
      in_item_i <= in_item_t'(IN_W'($urandom));
      repeat (pick_gap()) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full_o);
    expand_word(it);
    items_sent++;
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [15:0] color);
    in_item_t it;
    it.req_type      = REQ_PALETTE;
    it.palette_index = idx;
    it.data_word     = color;
    send_item(it);
  endtask

  task automatic send_data(input logic [15:0] word);
    in_item_t it;
    it.req_type      = REQ_DATA;
    it.palette_index = 8'($urandom);
    it.data_word     = word;
    send_item(it);
  endtask

  task automatic send_random_word();
    logic [15:0] word;
    word = 16'($urandom);
    if ($urandom_range(0, 9) == 0) send_palette(8'($urandom), 16'($urandom));
    if (cur_bpp == BPP_8 && !pal_valid[word[7:0]]) send_palette(word[7:0], 16'($urandom));
    send_data(word);
  endtask

  // register write; bits above the register width carry noise
  task automatic set_reg(input cfg_reg_e r, input logic [11:0] val);
    logic [11:0] wdata;
    wdata = 12'($urandom);
    case (r)
      REG_BPP_MODE: begin
        wdata[1:0] = val[1:0];
        cur_bpp    = bpp_e'(val[1:0]);
      end
      REG_STRETCH_FACTOR: begin
        wdata[3:0]  = val[3:0];
        cur_stretch = val[3:0];
      end
      REG_IMAGE_WIDTH: begin
        wdata[9:0] = val[9:0];
        cur_width  = val[9:0];
      end
      REG_IMAGE_HEIGHT: begin
        wdata[9:0] = val[9:0];
        cur_height = val[9:0];
      end
      REG_ORIGIN_X: begin
        wdata        = val;
        cur_origin_x = val;
      end
      default: begin
        wdata        = val;
        cur_origin_y = val;
      end
    endcase
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  task automatic wait_idle();
    push_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_palette_and_defaults();
    send_palette(8'd0, 16'h0000);
    send_palette(8'd1, 16'hFFFF);
    send_palette(8'd15, 16'h5AA5);
    send_palette(8'd255, 16'hA55A);
    // 8bpp after reset; upper byte must not matter
    send_data(16'hFFFF);
    send_data(16'h0100);
  endtask

  task automatic test_one_bpp_stretch();
    wait_idle();
    set_reg(REG_BPP_MODE, 12'(BPP_1));
    set_reg(REG_STRETCH_FACTOR, 12'd15);
    set_reg(REG_IMAGE_WIDTH, 12'd10);
    set_reg(REG_IMAGE_HEIGHT, 12'd1);
    set_reg(REG_ORIGIN_X, 12'd4090);
    set_reg(REG_ORIGIN_Y, 12'd4095);
    send_data(16'h00A5);
    send_data(16'hFF03);
    send_data(16'h5AC3);
  endtask

  task automatic test_zero_sizes();
    wait_idle();
    set_reg(REG_BPP_MODE, 12'(BPP_4));
    set_reg(REG_STRETCH_FACTOR, 12'd0);
    set_reg(REG_IMAGE_WIDTH, 12'd0);
    set_reg(REG_IMAGE_HEIGHT, 12'd0);
    send_data(16'h00F1);
    send_data(16'hFF1F);
  endtask

  task automatic test_direct_color();
    wait_idle();
    set_reg(REG_BPP_MODE, 12'(BPP_16));
    set_reg(REG_STRETCH_FACTOR, 12'd1);
    set_reg(REG_IMAGE_WIDTH, 12'd3);
    set_reg(REG_IMAGE_HEIGHT, 12'd2);
    set_reg(REG_ORIGIN_X, 12'd0);
    set_reg(REG_ORIGIN_Y, 12'd0);
    send_data(16'h0000);
    send_data(16'hFFFF);
    send_data(16'h8001);
    repeat (5) send_data(16'($urandom));
    // narrow the row under a column already past it
    wait_idle();
    set_reg(REG_IMAGE_WIDTH, 12'd1);
    send_data(16'h1234);
    send_data(16'hBEEF);
  endtask

  task automatic test_largest_sizes();
    wait_idle();
    set_reg(REG_BPP_MODE, 12'(BPP_8));
    set_reg(REG_STRETCH_FACTOR, 12'd8);
    set_reg(REG_IMAGE_WIDTH, 12'd1023);
    set_reg(REG_IMAGE_HEIGHT, 12'd1023);
    set_reg(REG_ORIGIN_X, 12'd4095);
    set_reg(REG_ORIGIN_Y, 12'd4095);
    send_data(16'h00FF);
    send_data(16'hFF00);
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_reg(REG_BPP_MODE, 12'(BPP_1));
    set_reg(REG_STRETCH_FACTOR, 12'd8);
    set_reg(REG_IMAGE_WIDTH, 12'd16);
    set_reg(REG_IMAGE_HEIGHT, 12'd2);
    set_reg(REG_ORIGIN_X, 12'd100);
    set_reg(REG_ORIGIN_Y, 12'd200);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_req     = HOLD_CYCLES;
    repeat (12) send_data(16'($urandom));
    wait_idle();
  endtask

  task automatic randomize_config();
    int r;
    if ($urandom_range(0, 2) != 0) set_reg(REG_BPP_MODE, 12'($urandom_range(0, 3)));
    if ($urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 9);
      if (r == 0) set_reg(REG_STRETCH_FACTOR, 12'd0);
      else if (r == 1) set_reg(REG_STRETCH_FACTOR, 12'($urandom_range(9, 15)));
      else if (r == 2) set_reg(REG_STRETCH_FACTOR, 12'd8);
      else set_reg(REG_STRETCH_FACTOR, 12'($urandom_range(1, 4)));
    end
    if ($urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 19);
      if (r == 0) set_reg(REG_IMAGE_WIDTH, 12'd0);
      else if (r == 1) set_reg(REG_IMAGE_WIDTH, 12'd1023);
      else set_reg(REG_IMAGE_WIDTH, 12'($urandom_range(1, 12)));
    end
    if ($urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 19);
      if (r == 0) set_reg(REG_IMAGE_HEIGHT, 12'd0);
      else if (r == 1) set_reg(REG_IMAGE_HEIGHT, 12'd1023);
      else set_reg(REG_IMAGE_HEIGHT, 12'($urandom_range(1, 3)));
    end
    if ($urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 3);
      set_reg(REG_ORIGIN_X, (r == 0) ? 12'($urandom_range(4080, 4095)) : 12'($urandom));
    end
    if ($urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 3);
      set_reg(REG_ORIGIN_Y, (r == 0) ? 12'($urandom_range(4090, 4095)) : 12'($urandom));
    end
  endtask

  task automatic test_random_images();
    int goal;
    int wpr;
    int img;
    int n;
    goal = TARGET_ITEMS;
    wait_idle();
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    for (int i = 0; i < 16; i++) send_palette(8'(i), 16'($urandom));
    while (items_sent < goal) begin
      wait_idle();
      randomize_config();
      tx_gap_pct   = pick_pct();
      rx_stall_pct = pick_pct();
      wpr = (eff_width() + pix_per_word() - 1) / pix_per_word();
      img = wpr * eff_height() * eff_stretch();
      n   = (img <= 48) ? img + $urandom_range(0, 2) : $urandom_range(1, 24);
      repeat (n) send_random_word();
    end
  endtask

  initial begin
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_palette_and_defaults();
    test_one_bpp_stretch();
    test_zero_sizes();
    test_direct_color();
    test_largest_sizes();
    test_backpressure();
    test_random_images();
    wait_idle();
    $display("%0d words sent, %0d pixels checked, %0d images finished, %0d register writes",
             items_sent, pixels_checked, images_seen, cfg_writes);
    $display("all four pixel formats, stretch 0..15, zero and maximum sizes, wrap, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
